>>> design/pfc_pkg.sv
// Shared constants, codes and types for the piecewise-linear fan curve.
// No dependencies; used by pfc_div, piecewise_linear_fan_curve, pfc_checker and tb.
package pfc_pkg;

	localparam int MAX_POINTS_DEF = 32;

	localparam int FUNC_W  = 2;
	localparam int TEMP_W  = 8;
	localparam int SPEED_W = 8;
	localparam int STAT_W  = 2;

	// (2*|num| + den) fits one bit above the product; divisor is 2*den
	localparam int MAG_W = SPEED_W + TEMP_W;
	localparam int DVD_W = MAG_W + 1;
	localparam int DVS_W = TEMP_W + 1;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [TEMP_W-1:0]  temp;
	} point_t;

endpackage

>>> design/pfc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pfc_pkg for default widths.
module pfc_div #(
	parameter int DVD_W = pfc_pkg::DVD_W,
	parameter int DVS_W = pfc_pkg::DVS_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/piecewise_linear_fan_curve.sv
// Piecewise-linear fan curve: key point store, list scan and rounded interpolation.
// Depends on pfc_pkg (codes, widths, point type) and pfc_div (serial divider).
//
//  channel  | dir | tdata                         | tuser
//  ---------+-----+-------------------------------+-------------
//  s_axis   | in  | [7:0] temperature, [15:8] speed | [1:0] func
//  m_axis   | out | [7:0] fan_speed                 | [1:0] status
//
// Clear, append, unused codes and empty-list queries go from accept straight
// to the respond step. A query over N stored points does one point memory
// read per cycle during the scan, then a multiply step and the bit-serial
// divider (one bit of the 17-bit dividend a cycle). arst_n clears the point
// count and the sequencer; the point memory is not cleared and is only read
// below the count. s_axis_tready is high only while the sequencer is idle;
// a result waits in the output register while the next beat is taken, and a
// stalled m_axis holds the sequencer in its respond step.
module piecewise_linear_fan_curve #(
	parameter int MAX_POINTS = pfc_pkg::MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] temperature, [15:8] speed
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] fan_speed
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	localparam int IW      = $clog2(MAX_POINTS);
	localparam int CW      = $clog2(MAX_POINTS + 1);
	localparam int TEMP_W  = pfc_pkg::TEMP_W;
	localparam int SPEED_W = pfc_pkg::SPEED_W;
	localparam int MAG_W   = pfc_pkg::MAG_W;
	localparam int DVD_W   = pfc_pkg::DVD_W;
	localparam int DVS_W   = pfc_pkg::DVS_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_DSTART = 3'd3;
	localparam logic [2:0] S_DWAIT  = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	// point store, one entry per key point
	pfc_pkg::point_t pt_mem [MAX_POINTS];

	logic [2:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic [TEMP_W-1:0]           temp_q;
	logic [CW-1:0]               scan_idx_q;
	logic                        rd_vld_q;
	logic                        rd_first_q;
	logic                        rd_last_q;
	pfc_pkg::point_t             rd_pt_q;
	pfc_pkg::point_t             prev_pt_q;
	logic [SPEED_W-1:0]          s1_q;
	logic [TEMP_W-1:0]           den_q;
	logic [TEMP_W-1:0]           dt_q;
	logic [SPEED_W-1:0]          ds_q;
	logic                        neg_q;
	logic [MAG_W-1:0]            mag_q;
	logic [SPEED_W-1:0]          res_speed_q;
	logic [pfc_pkg::STAT_W-1:0]  res_status_q;
	logic                        m_vld_q;
	logic [SPEED_W-1:0]          m_speed_q;
	logic [pfc_pkg::STAT_W-1:0]  m_status_q;

	logic [pfc_pkg::FUNC_W-1:0]  in_func;
	logic [TEMP_W-1:0]           in_temp;
	logic [SPEED_W-1:0]          in_speed;
	logic                        acc;
	logic                        has_room;
	logic                        issue;
	logic                        hit;
	logic                        div_start;
	logic                        div_done;
	logic [DVD_W-1:0]            div_dvd;
	logic [DVS_W-1:0]            div_dvs;
	logic [DVD_W-1:0]            div_quo;
	logic [SPEED_W-1:0]          q_off;

	assign in_func  = s_axis_tuser;
	assign in_temp  = s_axis_tdata[7:0];
	assign in_speed = s_axis_tdata[15:8];

	assign s_axis_tready = (state_q == S_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign has_room      = cnt_q < CW'(MAX_POINTS);

	// issue one memory read per cycle until every stored point is requested
	assign issue = (state_q == S_SCAN) && (scan_idx_q < cnt_q);
	// first point at or above the queried temperature ends the scan
	assign hit   = temp_q <= rd_pt_q.temp;

	// offset = floor((2*mag + den) / (2*den)), i.e. round half away from zero
	assign div_start = (state_q == S_DSTART);
	assign div_dvd   = {mag_q, 1'b0} + DVD_W'(den_q);
	assign div_dvs   = {den_q, 1'b0};
	assign q_off     = div_quo[SPEED_W-1:0];

	pfc_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// point memory: append writes at the fill count, the scan reads in order
	always_ff @(posedge clk) begin
		if (acc && in_func == pfc_pkg::FUNC_APPEND && has_room) begin
			pt_mem[cnt_q[IW-1:0]] <= '{speed: in_speed, temp: in_temp};
		end
		if (issue) begin
			rd_pt_q <= pt_mem[scan_idx_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			m_vld_q      <= 1'b0;
			rd_vld_q     <= 1'b0;
			rd_first_q   <= 1'b0;
			rd_last_q    <= 1'b0;
			scan_idx_q   <= '0;
		end else begin
			// drop the output beat once taken; the respond step refills it itself
			if (m_vld_q && m_axis_tready && state_q != S_RESP) begin
				m_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						temp_q       <= in_temp;
						res_speed_q  <= '0;
						res_status_q <= pfc_pkg::STAT_OK;
						rd_vld_q     <= 1'b0;
						scan_idx_q   <= '0;
						state_q      <= S_RESP;
						case (in_func)
							pfc_pkg::FUNC_CLEAR: begin
								cnt_q <= '0;
							end
							pfc_pkg::FUNC_APPEND: begin
								if (has_room) begin
									cnt_q <= cnt_q + 1'b1;
								end else begin
									res_status_q <= pfc_pkg::STAT_FULL;
								end
							end
							pfc_pkg::FUNC_QUERY: begin
								if (cnt_q == '0) begin
									res_status_q <= pfc_pkg::STAT_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								// unused code: answer zero, change nothing
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					rd_vld_q   <= issue;
					rd_first_q <= (scan_idx_q == '0);
					rd_last_q  <= (scan_idx_q == cnt_q - 1'b1);
					if (rd_vld_q) begin
						if (hit) begin
							if (rd_first_q) begin
								// at or below the first point: its speed
								res_speed_q <= rd_pt_q.speed;
								state_q     <= S_RESP;
							end else begin
								// above the previous point, at or below this one
								s1_q    <= prev_pt_q.speed;
								den_q   <= rd_pt_q.temp - prev_pt_q.temp;
								dt_q    <= temp_q - prev_pt_q.temp;
								neg_q   <= rd_pt_q.speed < prev_pt_q.speed;
								ds_q    <= (rd_pt_q.speed < prev_pt_q.speed) ?
								           (prev_pt_q.speed - rd_pt_q.speed) :
								           (rd_pt_q.speed - prev_pt_q.speed);
								state_q <= S_MUL;
							end
						end else begin
							prev_pt_q <= rd_pt_q;
							if (rd_last_q) begin
								// past the last point: hold its speed
								res_speed_q <= rd_pt_q.speed;
								state_q     <= S_RESP;
							end
						end
					end
				end
				S_MUL: begin
					mag_q   <= MAG_W'(ds_q) * MAG_W'(dt_q);
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						res_speed_q <= neg_q ? (s1_q - q_off) : (s1_q + q_off);
						state_q     <= S_RESP;
					end
				end
				S_RESP: begin
					if (!m_vld_q || m_axis_tready) begin
						m_vld_q    <= 1'b1;
						m_speed_q  <= res_speed_q;
						m_status_q <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_speed_q;
	assign m_axis_tuser  = m_status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count above capacity");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DWAIT)
		else $error("divider finished outside its wait step");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && state_q == S_DWAIT) |-> div_quo <= DVD_W'(ds_q))
		else $error("interpolation offset beyond the speed span");

	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_func == pfc_pkg::FUNC_QUERY && cnt_q == '0) |=>
		(state_q == S_RESP && res_status_q == pfc_pkg::STAT_EMPTY))
		else $error("empty-list query not flagged");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_func == pfc_pkg::FUNC_APPEND && !has_room) |=>
		($stable(cnt_q) && res_status_q == pfc_pkg::STAT_FULL))
		else $error("append on full list changed the list");

endmodule

>>> sim/pfc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for piecewise_linear_fan_curve: watches both stream channels,
// predicts each reply from its own copy of the key point list and compares.
// Depends on pfc_pkg for widths and codes.
module pfc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] temperature, [15:8] speed
	input  logic [1:0] s_axis_tuser,    // [1:0] func
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,    // [7:0] fan_speed
	input  logic [1:0] m_axis_tuser,    // [1:0] status
	output int         mismatches,
	output int         outstanding
);

	typedef struct packed {
		logic [pfc_pkg::SPEED_W-1:0] fan_speed;
		logic [pfc_pkg::STAT_W-1:0]  status;
	} fan_reply_t;

	logic [pfc_pkg::TEMP_W-1:0]  curve_temp  [pfc_pkg::MAX_POINTS_DEF];
	logic [pfc_pkg::SPEED_W-1:0] curve_speed [pfc_pkg::MAX_POINTS_DEF];
	int                          curve_len;
	fan_reply_t                  awaited_replies [$];
	int                          reports;

	function automatic logic [pfc_pkg::SPEED_W-1:0] blend_speed(int t1, int s1,
			int t2, int s2, int t);
		int den, dt, mag, q;
		den = t2 - t1;
		dt  = t - t1;
		if (s2 >= s1) begin
			mag = (s2 - s1) * dt;
			q   = (2 * mag + den) / (2 * den);
			return pfc_pkg::SPEED_W'(s1 + q);
		end
		mag = (s1 - s2) * dt;
		q   = (2 * mag + den) / (2 * den);
		return pfc_pkg::SPEED_W'(s1 - q);
	endfunction

	// Walk the list in stored order; unsorted entries are skipped unless bracketed.
	function automatic logic [pfc_pkg::SPEED_W-1:0] curve_fan_speed(int t);
		logic [pfc_pkg::SPEED_W-1:0] speed;
		bit                          found;
		int                          ti, tn;
		speed = '0;
		found = 1'b0;
		for (int i = 0; i < curve_len && !found; i++) begin
			ti = curve_temp[i];
			if (t <= ti) begin
				speed = curve_speed[i];
				found = 1'b1;
			end else if (i + 1 < curve_len) begin
				tn = curve_temp[i+1];
				if (t <= tn) begin
					speed = blend_speed(ti, curve_speed[i], tn, curve_speed[i+1], t);
					found = 1'b1;
				end
			end else begin
				speed = curve_speed[curve_len-1];
			end
		end
		return speed;
	endfunction

	function automatic fan_reply_t apply_beat(logic [1:0] func, logic [7:0] t,
			logic [7:0] s);
		fan_reply_t r;
		r.fan_speed = '0;
		r.status    = pfc_pkg::STAT_OK;
		case (func)
			pfc_pkg::FUNC_CLEAR: begin
				curve_len = 0;
			end
			pfc_pkg::FUNC_APPEND: begin
				if (curve_len < pfc_pkg::MAX_POINTS_DEF) begin
					curve_temp[curve_len]  = t;
					curve_speed[curve_len] = s;
					curve_len++;
				end else begin
					r.status = pfc_pkg::STAT_FULL;
				end
			end
			pfc_pkg::FUNC_QUERY: begin
				if (curve_len == 0)
					r.status = pfc_pkg::STAT_EMPTY;
				else
					r.fan_speed = curve_fan_speed(t);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fan_reply_t want;
		if (!arst_n) begin
			curve_len = 0;
			awaited_replies.delete();
			reports = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// retire the reply first: it belongs to an earlier beat
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_replies.size() == 0) begin
					if (reports < 10)
						$display("%0t: reply with none awaited: fan_speed %0d status %0d",
							$realtime, m_axis_tdata, m_axis_tuser);
					reports++;
					mismatches <= mismatches + 1;
				end else begin
					want = awaited_replies.pop_front();
					if (m_axis_tdata !== want.fan_speed || m_axis_tuser !== want.status) begin
						if (reports < 10)
							$display("%0t: expected fan_speed %0d status %0d, got %0d / %0d",
								$realtime, want.fan_speed, want.status,
								m_axis_tdata, m_axis_tuser);
						reports++;
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_replies.insert(awaited_replies.size(),
					apply_beat(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]));
			outstanding <= awaited_replies.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Top of the fan-curve testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on pfc_pkg, piecewise_linear_fan_curve and the pfc_checker scoreboard.
module tb;

	// Func code the block does not use; it must answer zero with status ok.
	localparam logic [pfc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 650;
	// A full-list query with stalls on each side stays under the limit; a span
	// this long with no beat on either channel means a hang.
	localparam int HANG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [7:0] temperature, [15:8] speed
	logic [1:0]  s_axis_tuser;   // [1:0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] fan_speed
	logic [1:0]  m_axis_tuser;   // [1:0] status

	int mismatches;
	int outstanding;
	int beats_sent;
	int quiet_cycles;
	bit no_idle;     // set for stretches where neither side inserts gaps

	piecewise_linear_fan_curve DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	pfc_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hang detector: count cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one beat: idle a random number of cycles, then hold valid until taken.
	// Valid and data change only at the falling edge, once per edge.
	task automatic send_beat(input logic [1:0] func, input logic [7:0] temp,
				 input logic [7:0] speed);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {speed, temp};
		s_axis_tuser  <= func;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		beats_sent++;
	endtask

	// Receiver: stall a random number of cycles per reply, then wait for it.
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			repeat (stall) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	// Stimulus
	initial begin
		int          npts;
		int          nprobe;
		int          kind;
		int          t;
		int          lo_t;
		int          hi_t;
		int          seq;
		bit          sorted;
		logic [7:0]  qt;

		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= pfc_pkg::FUNC_CLEAR;
		beats_sent    = 0;
		no_idle       = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty list, unused code, then a sorted curve probed below the
		// first point, at points and between them, and above 100 degrees.
		send_beat(pfc_pkg::FUNC_QUERY, 8'hFF, 8'hAA);
		send_beat(FUNC_UNUSED, 8'hFF, 8'hFF);
		send_beat(FUNC_UNUSED, 8'h00, 8'h00);
		send_beat(pfc_pkg::FUNC_APPEND, 8'd10, 8'd0);
		send_beat(pfc_pkg::FUNC_APPEND, 8'd40, 8'd255);
		send_beat(pfc_pkg::FUNC_APPEND, 8'd70, 8'd100);
		send_beat(pfc_pkg::FUNC_APPEND, 8'd255, 8'd200);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd0, 8'h55);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd10, 8'h00);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd25, 8'hFF);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd55, 8'h00);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd70, 8'h00);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd200, 8'h00);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd255, 8'h00);
		send_beat(pfc_pkg::FUNC_CLEAR, 8'hFF, 8'hFF);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd0, 8'h55);
		// unsorted list: skipped points and the answer past the end
		send_beat(pfc_pkg::FUNC_APPEND, 8'd50, 8'd100);
		send_beat(pfc_pkg::FUNC_APPEND, 8'd20, 8'd200);
		send_beat(pfc_pkg::FUNC_APPEND, 8'd80, 8'd10);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd30, 8'h00);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd60, 8'h00);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd90, 8'h00);
		send_beat(pfc_pkg::FUNC_QUERY, 8'd101, 8'h00);

		// Random: mostly clear / load / probe sequences, some noise beats.
		// Every sixth sequence, the first included, loads 28 to 36 points (capacity 32).
		seq = 0;
		while (beats_sent < 23 + RANDOM_BEATS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			kind    = $urandom_range(0, 9);
			if (kind == 0 && seq != 0) begin
				repeat ($urandom_range(1, 4))
					send_beat(pfc_pkg::FUNC_W'($urandom_range(0, 3)), 8'($urandom),
						8'($urandom));
			end else begin
				send_beat(pfc_pkg::FUNC_CLEAR, 8'($urandom), 8'($urandom));
				npts   = (seq % 6 == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
				sorted = ($urandom_range(0, 3) != 0);
				t      = $urandom_range(0, 60);
				lo_t   = t;
				hi_t   = t;
				for (int i = 0; i < npts; i++) begin
					if (!sorted)
						t = $urandom_range(0, 255);
					else if (i != 0)
						t = (t + $urandom_range(0, 40) > 255) ? 255 :
							t + $urandom_range(0, 40);
					if (t < lo_t) lo_t = t;
					if (t > hi_t) hi_t = t;
					send_beat(pfc_pkg::FUNC_APPEND, 8'(t), 8'($urandom));
				end
				nprobe = $urandom_range(3, 12);
				for (int i = 0; i < nprobe; i++) begin
					// mostly inside the curve, with a margin on both ends
					if ($urandom_range(0, 3) == 0)
						qt = 8'($urandom);
					else
						qt = 8'($urandom_range(lo_t < 5 ? 0 : lo_t - 5,
							hi_t > 250 ? 255 : hi_t + 5));
					send_beat(pfc_pkg::FUNC_QUERY, qt, 8'($urandom));
				end
			end
			seq++;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// Drain: wait for every awaited reply, then run on so a stray late reply is counted.
		while (outstanding != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
